@@ design/utf8_stream_decoder_top_defines.svh @@
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define UTF8D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define UTF8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/utf8d_pkg.sv @@
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int INDEX_WIDTH_DEFAULT = 16;
    localparam int BYTE_WIDTH          = 8;
    localparam int CP_WIDTH            = 21;
    localparam int CONT_SHIFT          = 6;
    localparam int STATUS_WIDTH        = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]          pending;
        logic [CP_WIDTH-1:0] partial;
        logic                err;
    } t_seq_state;

    typedef struct packed {
        logic [CP_WIDTH-1:0] code_point;
        t_status             status;
    } t_seq_result;

endpackage

@@ design/utf8d_step.sv @@
`timescale 1ns / 1ps

module utf8d_step #(
    parameter int INDEX_WIDTH = utf8d_pkg::INDEX_WIDTH_DEFAULT
) (
    input  utf8d_pkg::t_seq_state                i_seq,
    input  logic [INDEX_WIDTH-1:0]               i_index,
    input  logic [utf8d_pkg::BYTE_WIDTH-1:0]     i_byte,
    input  logic                                 i_first,
    input  logic                                 i_last,
    output utf8d_pkg::t_seq_state                o_seq,
    output logic [INDEX_WIDTH-1:0]               o_index,
    output logic                                 o_res_valid,
    output utf8d_pkg::t_seq_result               o_res,
    output logic [INDEX_WIDTH-1:0]               o_res_index
);

    localparam int CP_W = utf8d_pkg::CP_WIDTH;
    localparam int SH   = utf8d_pkg::CONT_SHIFT;

    utf8d_pkg::t_seq_state  cur_seq;
    logic [INDEX_WIDTH-1:0] cur_index;
    logic [CP_W-1:0]        acc_value;
    logic                   lead_ok;
    logic                   do_emit;
    logic                   do_fail;
    logic [CP_W-1:0]        emit_cp;
    utf8d_pkg::t_status     fail_status;

    always_comb begin
        cur_seq   = i_first ? '0 : i_seq;
        cur_index = i_first ? '0 : i_index;
        acc_value = {cur_seq.partial[CP_W-SH-1:0], i_byte[SH-1:0]};
    end

    always_comb begin
        o_seq       = cur_seq;
        lead_ok     = 1'b0;
        do_emit     = 1'b0;
        do_fail     = 1'b0;
        emit_cp     = '0;
        fail_status = utf8d_pkg::ST_OK;
        if (!cur_seq.err) begin
            if (cur_seq.pending == 2'd0) begin
                if (!i_byte[7]) begin
                    do_emit = 1'b1;
                    emit_cp = {{(CP_W-utf8d_pkg::BYTE_WIDTH){1'b0}}, i_byte};
                end else if (i_byte[7:5] == 3'b110) begin
                    lead_ok       = 1'b1;
                    o_seq.partial = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                    o_seq.pending = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    lead_ok       = 1'b1;
                    o_seq.partial = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                    o_seq.pending = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    lead_ok       = 1'b1;
                    o_seq.partial = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                    o_seq.pending = 2'd3;
                end else begin
                    do_fail     = 1'b1;
                    fail_status = utf8d_pkg::ST_BAD_LEAD;
                end
                if (lead_ok && i_last) begin
                    do_fail     = 1'b1;
                    fail_status = utf8d_pkg::ST_TRUNC;
                end
            end else if (i_last && cur_seq.pending > 2'd1) begin
                do_fail     = 1'b1;
                fail_status = utf8d_pkg::ST_TRUNC;
            end else if (i_byte[7:6] != 2'b10) begin
                do_fail     = 1'b1;
                fail_status = utf8d_pkg::ST_BAD_CONT;
            end else if (cur_seq.pending == 2'd1) begin
                do_emit = 1'b1;
                emit_cp = acc_value;
            end else begin
                o_seq.partial = acc_value;
                o_seq.pending = cur_seq.pending - 2'd1;
            end
        end
        if (do_emit) begin
            o_seq = '0;
        end else if (do_fail) begin
            o_seq     = '0;
            o_seq.err = 1'b1;
        end
    end

    always_comb begin
        o_res_valid    = do_emit || do_fail;
        o_res_index    = cur_index;
        o_res.code_point = do_emit ? emit_cp : '0;
        o_res.status   = do_emit ? utf8d_pkg::ST_OK : fail_status;
        if (do_emit && !(&cur_index)) begin
            o_index = cur_index + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
        end else begin
            o_index = cur_index;
        end
    end

endmodule

@@ design/utf8_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// Each byte accepted on the slave side is registered at the input, decoded, and its result
// beat is registered for the master side. Throughput: one byte per cycle; the decode step is
// combinational on the sequence state, and the master side stalls the input only when its output register is full.
// Reset: synchronous, active low; clears the sequence state, the error flag, the index
// and both valid flags.
module utf8_stream_decoder_top #(
    parameter int INDEX_WIDTH = utf8d_pkg::INDEX_WIDTH_DEFAULT,
    localparam int OUT_TDATA_W =
        ((utf8d_pkg::CP_WIDTH + INDEX_WIDTH + 7) / 8) * 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [utf8d_pkg::BYTE_WIDTH-1:0]      s_axis_tdata,  // [7:0] data_byte
    input  logic                                  s_axis_tuser,  // [0] first_byte
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata,  // code_point, char_index, zero pad
    output logic [utf8d_pkg::STATUS_WIDTH-1:0]    m_axis_tuser   // status
);

    localparam int CP_W = utf8d_pkg::CP_WIDTH;
    localparam int PAD_W = OUT_TDATA_W - CP_W - INDEX_WIDTH;

    logic                             r_in_valid;
    logic [utf8d_pkg::BYTE_WIDTH-1:0] r_in_byte;
    logic                             r_in_first;
    logic                             r_in_last;

    utf8d_pkg::t_seq_state            r_seq;
    logic [INDEX_WIDTH-1:0]           r_index;

    logic                             r_out_valid;
    utf8d_pkg::t_seq_result           r_out_res;
    logic [INDEX_WIDTH-1:0]           r_out_index;

    utf8d_pkg::t_seq_state            n_seq;
    logic [INDEX_WIDTH-1:0]           n_index;
    logic                             step_valid;
    utf8d_pkg::t_seq_result           step_res;
    logic [INDEX_WIDTH-1:0]           step_index;
    logic                             advance;
    logic                             take;

    assign advance       = !r_out_valid || m_axis_tready;
    assign take          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    utf8d_step #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_step (
        .i_seq       (r_seq),
        .i_index     (r_index),
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .i_last      (r_in_last),
        .o_seq       (n_seq),
        .o_index     (n_index),
        .o_res_valid (step_valid),
        .o_res       (step_res),
        .o_res_index (step_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_index <= '0;
        end else if (take) begin
            r_seq   <= n_seq;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= take && step_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && step_valid) begin
            r_out_res   <= step_res;
            r_out_index <= step_index;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_index, r_out_res.code_point};
    assign m_axis_tuser  = r_out_res.status;

endmodule

@@ design/utf8d_checker.sv @@
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_defines.svh"

module utf8d_checker #(
    parameter int INDEX_WIDTH = utf8d_pkg::INDEX_WIDTH_DEFAULT,
    localparam int OUT_TDATA_W =
        ((utf8d_pkg::CP_WIDTH + INDEX_WIDTH + 7) / 8) * 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [utf8d_pkg::BYTE_WIDTH-1:0]   s_axis_tdata,
    input logic                               s_axis_tuser,
    input logic                               s_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [OUT_TDATA_W-1:0]             m_axis_tdata,
    input logic [utf8d_pkg::STATUS_WIDTH-1:0] m_axis_tuser
);

    logic m_stall;
    logic m_is_err;
    logic s_idle_ok;

    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign m_is_err  = m_axis_tuser != utf8d_pkg::ST_OK;
    assign s_idle_ok = s_axis_tvalid || s_axis_tuser || s_axis_tlast || (|s_axis_tdata)
                       || !s_axis_tvalid;

    `UTF8D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
    `UTF8D_ASSERT_NOW(a_err_zero_cp, i_clk, i_rst_n, m_axis_tvalid && m_is_err, m_axis_tdata[utf8d_pkg::CP_WIDTH-1:0] == '0, "error beat carries a nonzero code point")
    `UTF8D_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid && s_idle_ok, s_axis_tready, "input stalled while output register is empty")
    `UTF8D_ASSERT_NOW(a_clear_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !m_axis_tvalid, "result beat offered right after reset")

endmodule

bind utf8_stream_decoder_top utf8d_checker #(
    .INDEX_WIDTH (INDEX_WIDTH)
) u_utf8d_checker (.*);

@@ tb/utf8_result_checker.sv @@
`timescale 1ns / 1ps

module utf8_result_checker #(
    parameter int INDEX_WIDTH = utf8d_pkg::INDEX_WIDTH_DEFAULT,
    localparam int OUT_W = ((utf8d_pkg::CP_WIDTH + INDEX_WIDTH + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [utf8d_pkg::BYTE_WIDTH-1:0]    i_in_data,
    input  logic                                i_in_first,
    input  logic                                i_in_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [OUT_W-1:0]                    i_out_data,
    input  logic [utf8d_pkg::STATUS_WIDTH-1:0]  i_out_status,
    output int                                  o_fail_count,
    output int                                  o_due_count,
    output int                                  o_live_beats
);

    import utf8d_pkg::*;

    typedef struct packed {
        logic [CP_WIDTH-1:0]    cp;
        logic [INDEX_WIDTH-1:0] idx;
        t_status                st;
    } t_point;

    logic [1:0]             seq_left;
    logic [CP_WIDTH-1:0]    seq_bits;
    logic                   seq_err;
    logic [INDEX_WIDTH-1:0] str_index;
    t_point                 due_points[$];
    int                     fails = 0;
    int                     live = 0;

    function automatic void raise_error(input t_status st, output t_point pt);
        pt.cp    = '0;
        pt.idx   = str_index;
        pt.st    = st;
        seq_err  = 1'b1;
        seq_left = '0;
        seq_bits = '0;
    endfunction

    function automatic void finish_point(input logic [CP_WIDTH-1:0] cp, output t_point pt);
        pt.cp  = cp;
        pt.idx = str_index;
        pt.st  = ST_OK;
        if (str_index != '1) begin
            str_index = str_index + 1'b1;
        end
        seq_left = '0;
        seq_bits = '0;
    endfunction

    function automatic bit decode_step(input logic [BYTE_WIDTH-1:0] b, input logic first,
                                       input logic last, output t_point pt);
        pt = '0;
        if (first) begin
            seq_left  = '0;
            seq_bits  = '0;
            seq_err   = 1'b0;
            str_index = '0;
        end
        if (seq_err) begin
            return 1'b0;
        end
        if (seq_left == 2'd0) begin
            if (!b[7]) begin
                finish_point(CP_WIDTH'(b), pt);
                return 1'b1;
            end
            if (b[7:5] == 3'b110) begin
                seq_bits = CP_WIDTH'(b[4:0]);
                seq_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                seq_bits = CP_WIDTH'(b[3:0]);
                seq_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                seq_bits = CP_WIDTH'(b[2:0]);
                seq_left = 2'd3;
            end else begin
                raise_error(ST_BAD_LEAD, pt);
                return 1'b1;
            end
            if (last) begin
                raise_error(ST_TRUNC, pt);
                return 1'b1;
            end
            return 1'b0;
        end
        if (last && seq_left > 2'd1) begin
            raise_error(ST_TRUNC, pt);
            return 1'b1;
        end
        if (b[7:6] != 2'b10) begin
            raise_error(ST_BAD_CONT, pt);
            return 1'b1;
        end
        seq_bits = {seq_bits[CP_WIDTH-CONT_SHIFT-1:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
            finish_point(seq_bits, pt);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_point want;
        t_point got;
        if (!i_rst_n) begin
            seq_left  = '0;
            seq_bits  = '0;
            seq_err   = 1'b0;
            str_index = '0;
            due_points.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.cp  = i_out_data[CP_WIDTH-1:0];
                got.idx = i_out_data[CP_WIDTH +: INDEX_WIDTH];
                got.st  = t_status'(i_out_status);
                if (due_points.size() == 0) begin
                    $error("unexpected result beat: code_point=%0h char_index=%0d status=%0d",
                           got.cp, got.idx, got.st);
                    fails++;
                end else begin
                    want = due_points.pop_front();
                    if (got.cp !== want.cp) begin
                        $error("code_point: expected %0h, got %0h", want.cp, got.cp);
                        fails++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("char_index: expected %0d, got %0d", want.idx, got.idx);
                        fails++;
                    end
                    if (got.st !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, got.st);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (decode_step(i_in_data, i_in_first, i_in_last, want)) begin
                    due_points.push_back(want);
                end
                live++;
            end
        end
        o_fail_count = fails;
        o_due_count  = due_points.size();
        o_live_beats = live;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import utf8d_pkg::*;

    localparam int IDX_W    = INDEX_WIDTH_DEFAULT;
    localparam int OUT_W    = ((CP_WIDTH + IDX_W + 7) / 8) * 8;
    localparam int N_DIRECT = 26;

    // {first_byte, last_byte, data_byte}
    localparam logic [9:0] DIRECT_BEATS [N_DIRECT] = '{
        {2'b11, 8'h41},
        {2'b10, 8'h00}, {2'b00, 8'hC2}, {2'b00, 8'hA9},
        {2'b00, 8'hE2}, {2'b00, 8'h82}, {2'b00, 8'hAC},
        {2'b00, 8'hF7}, {2'b00, 8'hBF}, {2'b00, 8'hBF}, {2'b00, 8'hBF},
        {2'b00, 8'hC0}, {2'b01, 8'h80},
        {2'b00, 8'h7F},
        {2'b10, 8'h80}, {2'b00, 8'h41},
        {2'b11, 8'hFF},
        {2'b10, 8'hF8},
        {2'b10, 8'hE2}, {2'b01, 8'h41},
        {2'b10, 8'hC3}, {2'b00, 8'h41},
        {2'b11, 8'hF0},
        {2'b10, 8'hF0}, {2'b00, 8'h90}, {2'b01, 8'h80}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [BYTE_WIDTH-1:0]   s_axis_tdata;  // [7:0] data_byte
    logic                    s_axis_tuser;  // [0] first_byte
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_W-1:0]        m_axis_tdata;  // [20:0] code_point, [36:21] char_index, zero pad
    logic [STATUS_WIDTH-1:0] m_axis_tuser;  // [1:0] status

    int   fail_count;
    int   due_count;
    int   live_beats;
    bit   no_idle;
    bit   hold_req;
    logic [7:0] str_buf[$];

    utf8_stream_decoder_top #(
        .INDEX_WIDTH(IDX_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    utf8_result_checker #(
        .INDEX_WIDTH(IDX_W)
    ) result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_first  (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_status(m_axis_tuser),
        .o_fail_count(fail_count),
        .o_due_count (due_count),
        .o_live_beats(live_beats)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin : rx_side
        int stall_left;
        bit hold_done;
        stall_left    = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_char();
        int r;
        int n_cont;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            str_buf.push_back({1'b0, 7'($urandom_range(0, 127))});
            n_cont = 0;
        end else if (r < 6) begin
            str_buf.push_back({3'b110, 5'($urandom_range(0, 31))});
            n_cont = 1;
        end else if (r < 8) begin
            str_buf.push_back({4'b1110, 4'($urandom_range(0, 15))});
            n_cont = 2;
        end else begin
            str_buf.push_back({5'b11110, 3'($urandom_range(0, 7))});
            n_cont = 3;
        end
        repeat (n_cont) str_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
    endtask

    task automatic send_string(input int n_chars);
        int r;
        int last_pos;
        bit with_first;
        str_buf.delete();
        repeat (n_chars) add_char();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 12 && str_buf.size() > 1) begin
            str_buf.delete($urandom_range(0, str_buf.size() - 1));
        end else if (r < 16) begin
            str_buf.insert($urandom_range(0, str_buf.size()),
                           {2'b10, 6'($urandom_range(0, 63))});
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            last_pos = -1;
        end else if (r < 25) begin
            last_pos = $urandom_range(0, str_buf.size() - 1);
        end else begin
            last_pos = str_buf.size() - 1;
        end
        with_first = ($urandom_range(0, 19) != 0);
        foreach (str_buf[i]) begin
            put_byte(str_buf[i], with_first && i == 0, i == last_pos);
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) begin
            put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                     $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic run_random(input int target);
        while (live_beats < target) begin
            if ($urandom_range(0, 9) == 0) begin
                send_noise($urandom_range(1, 6));
            end else begin
                send_string($urandom_range(1, 10));
            end
        end
    endtask

    initial begin
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECT_BEATS[i]) begin
            put_byte(DIRECT_BEATS[i][7:0], DIRECT_BEATS[i][9], DIRECT_BEATS[i][8]);
        end

        run_random(650);

        // drain before the long receiver hold
        s_axis_tvalid <= 1'b0;
        wait (due_count == 0);
        @(negedge i_clk);
        hold_req = 1'b1;
        no_idle  = 1'b1;
        run_random(800);
        no_idle  = 1'b0;
        run_random(1300);

        s_axis_tvalid <= 1'b0;
        wait (due_count == 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
